/* rtl/bls_pkg.sv */
`timescale 1ns / 1ps
package bls_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int POS_W = 4;
  localparam int IDXO_W = 4;
  localparam int ST_W  = 3;
  localparam int CNTO_W = 5;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_SEARCH    = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DEL_POS   = 3'd4,
    OP_DEL_VALUE = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT_UP,
    S_INS_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [IDXO_W-1:0]       index;
    logic signed [VAL_W-1:0] found_value;
    logic [CNTO_W-1:0]       count;
  } out_item_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_key;
  } mem_cmd_t;

endpackage

/* rtl/bls_store.sv */
`timescale 1ns / 1ps
module bls_store import bls_pkg::*; (
  input  logic                    clk_i,
  input  mem_cmd_t                cmd_i,
  input  logic signed [VAL_W-1:0] key_i,
  output logic signed [VAL_W-1:0] rd_data_o,
  output logic                    match_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rd_data_q;
  logic signed [VAL_W-1:0] wr_data;

  assign wr_data = cmd_i.wr_key ? key_i : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign match_o   = (rd_data_q == key_i);

endmodule

/* rtl/bls_ctrl.sv */
`timescale 1ns / 1ps
module bls_ctrl import bls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    res_valid_o,
  output out_item_t               res_o,
  input  logic                    res_take_i,
  output mem_cmd_t                cmd_o,
  output logic signed [VAL_W-1:0] key_o,
  input  logic signed [VAL_W-1:0] rd_data_i,
  input  logic                    match_i
);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]        tgt_q, tgt_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    issue_q, issue_d;
  logic                    dv_q, dv_d;
  logic [IDX_W-1:0]        didx_q, didx_d;
  logic                    hit_q, hit_d;
  out_item_t               res_q, res_d;

  logic                    accept;
  logic                    empty;
  logic                    full;
  logic                    pos_oor;
  logic                    by_value;
  logic                    walk_match;
  logic                    dv_last;
  logic                    walk_end;
  logic [CNT_W-1:0]        last_cnt;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign empty      = (used_q == '0);
  assign full       = (used_q >= FULL_CNT);
  assign pos_oor    = (CNT_W'(in_item_i.position) >= used_q);
  assign last_cnt   = used_q - 1'b1;
  assign by_value   = (op_q == OP_SEARCH) || (op_q == OP_DEL_VALUE);
  assign walk_match = by_value ? match_i : (didx_q == tgt_q);
  assign dv_last    = dv_q && (CNT_W'(didx_q) == last_cnt);
  assign walk_end   = dv_q && ((!hit_q && walk_match && (op_q == OP_SEARCH)) || dv_last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.operation)
            OP_INSERT: begin
              if (full) begin
                state_d = S_DONE;
              end else if (empty) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_SHIFT_UP;
              end
            end
            OP_SEARCH, OP_DEL_VALUE, OP_DEL_FRONT, OP_DEL_BACK: begin
              state_d = empty ? S_DONE : S_WALK;
            end
            OP_DEL_POS: begin
              state_d = (empty || pos_oor) ? S_DONE : S_WALK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (dv_q && (didx_q == '0)) begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    used_d  = used_q;
    op_d    = op_q;
    key_d   = key_q;
    tgt_d   = tgt_q;
    ptr_d   = ptr_q;
    issue_d = issue_q;
    dv_d    = 1'b0;
    didx_d  = didx_q;
    hit_d   = hit_q;
    res_d   = res_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_item_i.operation;
          key_d   = in_item_i.value;
          hit_d   = 1'b0;
          issue_d = 1'b1;
          res_d.status      = ST_OK;
          res_d.index       = '0;
          res_d.found_value = '0;
          res_d.count       = CNTO_W'(used_q);
          case (in_item_i.operation)
            OP_INSERT: begin
              ptr_d = last_cnt;
              if (full) begin
                res_d.status = ST_FULL;
              end
            end
            OP_SEARCH, OP_DEL_VALUE: begin
              ptr_d = '0;
              if (empty) begin
                res_d.status = ST_EMPTY;
              end
            end
            OP_DEL_FRONT: begin
              tgt_d = '0;
              ptr_d = '0;
              if (empty) begin
                res_d.status = ST_EMPTY;
              end
            end
            OP_DEL_BACK: begin
              tgt_d = IDX_W'(last_cnt);
              ptr_d = last_cnt;
              if (empty) begin
                res_d.status = ST_EMPTY;
              end
            end
            OP_DEL_POS: begin
              tgt_d = IDX_W'(in_item_i.position);
              ptr_d = CNT_W'(in_item_i.position);
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else if (pos_oor) begin
                res_d.status = ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cmd_o.rd_en   = issue_q;
        cmd_o.rd_addr = ptr_q[IDX_W-1:0];
        dv_d          = issue_q;
        didx_d        = ptr_q[IDX_W-1:0];
        if (issue_q) begin
          ptr_d   = ptr_q + 1'b1;
          issue_d = (ptr_q != last_cnt);
        end
        if (dv_q) begin
          if (!hit_q) begin
            if (walk_match) begin
              hit_d             = 1'b1;
              res_d.index       = IDXO_W'(didx_q);
              res_d.found_value = rd_data_i;
              if ((op_q != OP_SEARCH) && dv_last) begin
                used_d      = last_cnt;
                res_d.count = CNTO_W'(last_cnt);
              end
            end else if (dv_last) begin
              res_d.status = ST_MISSING;
            end
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = didx_q - 1'b1;
            if (dv_last) begin
              used_d      = last_cnt;
              res_d.count = CNTO_W'(last_cnt);
            end
          end
        end
      end
      S_SHIFT_UP: begin
        cmd_o.rd_en   = issue_q;
        cmd_o.rd_addr = ptr_q[IDX_W-1:0];
        dv_d          = issue_q;
        didx_d        = ptr_q[IDX_W-1:0];
        if (issue_q) begin
          ptr_d   = ptr_q - 1'b1;
          issue_d = (ptr_q != '0);
        end
        if (dv_q) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = didx_q + 1'b1;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr     = '0;
        cmd_o.wr_key      = 1'b1;
        used_d            = used_q + 1'b1;
        res_d.index       = '0;
        res_d.found_value = key_q;
        res_d.count       = CNTO_W'(used_q + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      issue_q <= 1'b0;
      dv_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      issue_q <= issue_d;
      dv_q    <= dv_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    tgt_q  <= tgt_d;
    ptr_q  <= ptr_d;
    didx_q <= didx_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign key_o       = key_q;

endmodule

/* rtl/bounded_list_store_top.sv */
`timescale 1ns / 1ps
// Ordered store of up to 16 signed 32-bit values, front at index 0, held in a
// single-port-read, single-port-write memory. One command is taken at a time;
// stall stays high until its result moves to the output register. A command
// that walks the memory does so one entry per cycle through one read port,
// one write port and one 32-bit comparator: an insert shifts the entries up
// and writes its value at index 0, a search reads from the front up to the
// first hit or the end, and a delete at index k moves each later entry down
// (value deletes first search up to k). Error cases and unused codes finish
// without a walk. A result waits in an output register, and the next command
// is taken while it waits. Entries are not cleared at reset; none need be.
module bounded_list_store_top import bls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  mem_cmd_t                cmd;
  logic signed [VAL_W-1:0] key;
  logic signed [VAL_W-1:0] rd_data;
  logic                    match;
  logic                    res_valid;
  out_item_t               res;
  logic                    res_take;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .cmd_o       (cmd),
    .key_o       (key),
    .rd_data_i   (rd_data),
    .match_i     (match)
  );

  bls_store u_store (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .key_i     (key),
    .rd_data_o (rd_data),
    .match_o   (match)
  );

  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);
  assign out_item_d  = res_take ? res : out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/bls_checker.sv */
`timescale 1ns / 1ps
module bls_checker import bls_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while previous one still in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.count <= CNTO_W'(DEPTH)))
    else $error("count above depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_OK) |->
      (out_item_o.index == '0) && (out_item_o.found_value == '0))
    else $error("error result carries index or value");

endmodule

bind bounded_list_store_top bls_checker u_bls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* sim/tb_bounded_list_store_top.sv */
`timescale 1ns / 1ps
module tb_bounded_list_store_top;
  import bls_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP_7 = 3'd7;
  localparam int unsigned RANDOM_CMDS = 1290;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned CHOKE_AT = 300;
  localparam int unsigned CHOKE_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  typedef struct {
    in_item_t    cmd;
    int unsigned gap;
  } paced_cmd_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  paced_cmd_t        cmd_backlog[$];
  out_item_t         due_results[$];
  logic signed [31:0] shadow_list[DEPTH];
  int unsigned       shadow_len = 0;

  int unsigned idle_left = 0;
  int unsigned hold_left = 0;
  int unsigned choke_left = 0;
  logic        choke_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned accepted_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_cnt = 0;
  int unsigned status_hits[8] = '{default: 0};

  // cumulative weights over insert, search, del front, del back, del pos, del value, nop
  int unsigned op_cut[3][7] = '{
    '{60, 70, 75, 80, 88, 96, 100},
    '{15, 25, 40, 55, 75, 96, 100},
    '{35, 50, 60, 70, 82, 96, 100}
  };

  bounded_list_store_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic queue_cmd(logic [OP_W-1:0] op, logic signed [31:0] val,
                           logic [POS_W-1:0] pos, int unsigned gap);
    paced_cmd_t p;
    p.cmd.operation = op;
    p.cmd.value = val;
    p.cmd.position = pos;
    p.gap = gap;
    cmd_backlog.push_back(p);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    error_cnt++;
  endtask

  function automatic void shadow_remove(int unsigned at);
    for (int unsigned k = at; k + 1 < shadow_len; k++) begin
      shadow_list[k] = shadow_list[k + 1];
    end
    shadow_len--;
  endfunction

  function automatic out_item_t list_apply(in_item_t cmd);
    out_item_t   r;
    int          hit;
    int unsigned at;
    r = '0;
    hit = -1;
    case (cmd.operation)
      OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned k = shadow_len; k > 0; k--) begin
            shadow_list[k] = shadow_list[k - 1];
          end
          shadow_list[0] = cmd.value;
          shadow_len++;
          r.found_value = cmd.value;
        end
      end
      OP_SEARCH, OP_DEL_VALUE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int k = int'(shadow_len) - 1; k >= 0; k--) begin
            if (shadow_list[k] == cmd.value) hit = k;
          end
          if (hit < 0) begin
            r.status = ST_MISSING;
          end else begin
            r.index = IDXO_W'(hit);
            r.found_value = shadow_list[hit];
            if (cmd.operation == OP_DEL_VALUE) shadow_remove(hit);
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd.operation == OP_DEL_FRONT) at = 0;
          else if (cmd.operation == OP_DEL_BACK) at = shadow_len - 1;
          else at = cmd.position;
          if (at >= shadow_len) begin
            r.status = ST_RANGE;
          end else begin
            r.index = IDXO_W'(at);
            r.found_value = shadow_list[at];
            shadow_remove(at);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNTO_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic       fire;
    paced_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left <= 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        due_results.push_back(list_apply(in_item_i));
        accepted_cnt++;
      end
      if (in_valid_i && !fire) begin
        // hold the offered transfer
      end else if (idle_left != 0) begin
        in_valid_i <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        in_item_i <= nxt.cmd;
        in_valid_i <= 1'b1;
        idle_left <= nxt.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    int unsigned hold_v;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else begin
      hold_v = (hold_left != 0) ? hold_left - 1 : 0;
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, status", out_item_o.status, 0);
        end else begin
          want = due_results.pop_front();
          status_hits[want.status]++;
          if (out_item_o.status !== want.status)
            report_mismatch("status", out_item_o.status, want.status);
          if (out_item_o.index !== want.index)
            report_mismatch("index", out_item_o.index, want.index);
          if (out_item_o.found_value !== want.found_value)
            report_mismatch("found_value", longint'(out_item_o.found_value),
                            longint'(want.found_value));
          if (out_item_o.count !== want.count)
            report_mismatch("count", out_item_o.count, want.count);
        end
        hold_v = ((results_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 6);
      end
      hold_left <= hold_v;
      out_stall_i <= (hold_v != 0) || (choke_left > 1);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choke_left <= 0;
      choke_done <= 1'b0;
    end else if (!choke_done && results_seen >= CHOKE_AT) begin
      choke_left <= CHOKE_LEN;
      choke_done <= 1'b1;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cmd_backlog.size() == 0 && due_results.size() == 0 && !in_valid_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stall_cycles);
        $display("tb_bounded_list_store_top NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [31:0] pool[8];
    int unsigned        made;
    int unsigned        ep_len;
    int unsigned        roll;
    int unsigned        op;
    logic               quiet;
    logic signed [31:0] val;
    mix_e               mix;

    // empty list
    queue_cmd(OP_SEARCH, 32'sd7, 4'd0, $urandom_range(0, 6));
    queue_cmd(OP_DEL_FRONT, 32'sd0, 4'd0, $urandom_range(0, 6));
    queue_cmd(OP_DEL_BACK, 32'sd0, 4'd0, $urandom_range(0, 6));
    queue_cmd(OP_DEL_POS, 32'sd0, 4'd0, $urandom_range(0, 6));
    queue_cmd(OP_DEL_VALUE, 32'sd7, 4'd0, $urandom_range(0, 6));
    queue_cmd(OP_NOP_6, 32'sd0, 4'd15, 0);
    queue_cmd(OP_NOP_7, -32'sd1, 4'd9, 0);
    // fill to the top with extremes mixed in
    queue_cmd(OP_INSERT, 32'sh8000_0000, 4'd0, 0);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 4'd15, 0);
    queue_cmd(OP_INSERT, 32'sd0, 4'd0, 0);
    queue_cmd(OP_INSERT, -32'sd1, 4'd0, 0);
    for (int k = 0; k < 12; k++) begin
      queue_cmd(OP_INSERT, $urandom(), POS_W'($urandom_range(0, 15)),
                $urandom_range(0, 2));
    end
    queue_cmd(OP_INSERT, 32'sd5, 4'd0, 0);
    queue_cmd(OP_SEARCH, 32'sh7fff_ffff, 4'd0, 0);
    queue_cmd(OP_SEARCH, 32'sd12345, 4'd0, 0);
    queue_cmd(OP_DEL_VALUE, 32'sh8000_0000, 4'd0, 0);
    queue_cmd(OP_DEL_VALUE, 32'sd12345, 4'd0, 0);
    queue_cmd(OP_DEL_FRONT, 32'sd0, 4'd0, 0);
    queue_cmd(OP_DEL_BACK, 32'sd0, 4'd0, 0);
    queue_cmd(OP_DEL_POS, 32'sd0, 4'd15, 0);
    queue_cmd(OP_DEL_POS, 32'sd0, 4'd5, 0);

    made = 0;
    while (made < RANDOM_CMDS) begin
      mix = mix_e'($urandom_range(0, 2));
      ep_len = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 8; k++) begin
        roll = $urandom_range(0, 9);
        if (roll < 5) pool[k] = $urandom();
        else if (roll < 8) pool[k] = $signed($urandom_range(0, 8)) - 4;
        else if (roll == 8) pool[k] = 32'sh8000_0000;
        else pool[k] = 32'sh7fff_ffff;
      end
      repeat (ep_len) begin
        roll = $urandom_range(0, 99);
        op = 0;
        while (roll >= op_cut[mix][op]) op++;
        val = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 7)] : $urandom();
        if (op == 6) begin
          queue_cmd(($urandom_range(0, 1) != 0) ? OP_NOP_7 : OP_NOP_6, val,
                    POS_W'($urandom_range(0, 15)), quiet ? 0 : $urandom_range(0, 6));
        end else begin
          queue_cmd(OP_W'(op), val, POS_W'($urandom_range(0, 15)),
                    quiet ? 0 : $urandom_range(0, 6));
        end
        made++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands accepted, %0d results checked", accepted_cnt, results_seen);
    $display("statuses: ok %0d, empty %0d, full %0d, missing %0d, out of range %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_MISSING], status_hits[ST_RANGE]);
    if (error_cnt == 0 && due_results.size() == 0) begin
      $display("tb_bounded_list_store_top OK");
    end else begin
      $display("tb_bounded_list_store_top NOT OK");
    end
    $finish;
  end

endmodule
